// ===== hdl/lgen_pkg.sv =====
// Shared constants, types and helpers for the life generation engine.
// No dependencies; used by life_generation_engine and lgen_row_calc.
`timescale 1ns / 1ps

package lgen_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int NR_W     = $clog2(MAX_ROWS + 1);
  localparam int NC_W     = $clog2(MAX_COLS + 1);
  localparam int CFG_W    = 7;
  localparam int OP_W     = 2;
  localparam int IDX_W    = 6;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_GEN   = 2'd2;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef logic [MAX_COLS-1:0] row_t;

  typedef struct packed {
    row_t prev;
    row_t cur;
    row_t nxt;
  } win_t;

  function automatic logic [NR_W-1:0] bound_rows(input logic [CFG_W-1:0] v);
    if (v == '0) return NR_W'(1);
    if (32'(v) > MAX_ROWS) return NR_W'(MAX_ROWS);
    return NR_W'(v);
  endfunction

  function automatic logic [NC_W-1:0] bound_cols(input logic [CFG_W-1:0] v);
    if (v == '0) return NC_W'(1);
    if (32'(v) > MAX_COLS) return NC_W'(MAX_COLS);
    return NC_W'(v);
  endfunction

endpackage

// ===== hdl/life_generation_engine.sv =====
// Top level: sequencer around the row-wide grid memory and the row update lanes.
// Depends on lgen_pkg, lgen_ram and lgen_row_calc.
//
//   channel | direction | signals
//   --------+-----------+---------------------------------------------------
//   in      | sink      | in_valid, in_ready, in_op, in_row, in_column, in_cell_in
//   out     | source    | out_valid, out_ready, out_cell_out, out_generation_done
//   cfg     | sink      | cfg_we, cfg_addr, cfg_wdata (write only)
//
// A cell write or read in the active area goes through memory read, modify or pick,
// and result; one outside the active area, or an unused op, through accept and result.
// In a generation each row is fetched and then computed and written back in the next
// cycle, as read data lags its address.
// After reset a clearing pass over all MAX_ROWS (64) rows zeroes the grid; no beat is
// accepted meanwhile. One item is in work at a time; a pending result stalls
// only the result step of the next item.
`timescale 1ns / 1ps

module life_generation_engine (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic                         cfg_addr,
  input  logic [lgen_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lgen_pkg::OP_W-1:0]    in_op,
  input  logic [lgen_pkg::IDX_W-1:0]   in_row,
  input  logic [lgen_pkg::IDX_W-1:0]   in_column,
  input  logic                         in_cell_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_cell_out,
  output logic                         out_generation_done
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL_DO,
    ST_G_FIRST,
    ST_G_LOAD,
    ST_G_FETCH,
    ST_G_CALC,
    ST_RESULT
  } state_t;

  state_t                        state_r, state_nxt;
  logic [lgen_pkg::CFG_W-1:0]    rows_cfg_r, cols_cfg_r;
  logic [lgen_pkg::OP_W-1:0]     op_r, op_nxt;
  logic [lgen_pkg::IDX_W-1:0]    row_r, row_nxt;
  logic [lgen_pkg::IDX_W-1:0]    col_r, col_nxt;
  logic                          cell_r, cell_nxt;
  logic                          res_cell_r, res_cell_nxt;
  logic [lgen_pkg::ROW_W-1:0]    gen_row_r, gen_row_nxt;
  lgen_pkg::row_t                prev_r, prev_nxt;
  lgen_pkg::row_t                cur_r, cur_nxt;
  lgen_pkg::row_t                first_r, first_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_cell_r, out_cell_nxt;
  logic                          out_done_r, out_done_nxt;

  logic [lgen_pkg::NR_W-1:0]     nr;
  logic [lgen_pkg::NC_W-1:0]     nc;
  logic [lgen_pkg::ROW_W-1:0]    last_row;
  logic                          in_inside;
  logic                          accept;
  logic                          gen_last;

  logic                          ram_we, ram_re;
  logic [lgen_pkg::ROW_W-1:0]    ram_waddr, ram_raddr;
  lgen_pkg::row_t                ram_wdata, ram_rdata;
  lgen_pkg::row_t                nxt_row, new_row;
  lgen_pkg::win_t                win;

  assign nr        = lgen_pkg::bound_rows(rows_cfg_r);
  assign nc        = lgen_pkg::bound_cols(cols_cfg_r);
  assign last_row  = lgen_pkg::ROW_W'(nr - 1'b1);
  assign in_inside = (32'(in_row) < 32'(nr)) && (32'(in_column) < 32'(nc));
  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign gen_last  = (gen_row_r == last_row);
  assign nxt_row   = gen_last ? first_r : ram_rdata;

  assign win.prev = prev_r;
  assign win.cur  = cur_r;
  assign win.nxt  = nxt_row;

  lgen_ram #(
    .WIDTH (lgen_pkg::MAX_COLS),
    .DEPTH (lgen_pkg::MAX_ROWS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lgen_row_calc u_calc (
    .win     (win),
    .nc      (nc),
    .new_row (new_row)
  );

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    cell_nxt      = cell_r;
    res_cell_nxt  = res_cell_r;
    gen_row_nxt   = gen_row_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    first_nxt     = first_r;
    out_valid_nxt = out_valid_r;
    out_cell_nxt  = out_cell_r;
    out_done_nxt  = out_done_r;
    ram_we        = 1'b0;
    ram_waddr     = gen_row_r;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = lgen_pkg::ROW_W'(in_row);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        gen_row_nxt = gen_row_r + 1'b1;
        if (32'(gen_row_r) == lgen_pkg::MAX_ROWS - 1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          op_nxt       = in_op;
          row_nxt      = in_row;
          col_nxt      = in_column;
          cell_nxt     = in_cell_in;
          res_cell_nxt = 1'b0;
          case (in_op)
            lgen_pkg::OP_WRITE, lgen_pkg::OP_READ: begin
              if (in_inside) begin
                ram_re    = 1'b1;
                state_nxt = ST_CELL_DO;
              end else begin
                state_nxt = ST_RESULT;
              end
            end
            lgen_pkg::OP_GEN: begin
              ram_re    = 1'b1;
              ram_raddr = last_row;
              state_nxt = ST_G_FIRST;
            end
            default: begin
              state_nxt = ST_RESULT;
            end
          endcase
        end
      end
      ST_CELL_DO: begin
        if (op_r == lgen_pkg::OP_WRITE) begin
          ram_we    = 1'b1;
          ram_waddr = lgen_pkg::ROW_W'(row_r);
          ram_wdata = ram_rdata;
          ram_wdata[lgen_pkg::COL_W'(col_r)] = cell_r;
        end else begin
          res_cell_nxt = ram_rdata[lgen_pkg::COL_W'(col_r)];
        end
        state_nxt = ST_RESULT;
      end
      ST_G_FIRST: begin
        prev_nxt  = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = '0;
        state_nxt = ST_G_LOAD;
      end
      ST_G_LOAD: begin
        cur_nxt     = ram_rdata;
        first_nxt   = ram_rdata;
        gen_row_nxt = '0;
        state_nxt   = ST_G_FETCH;
      end
      ST_G_FETCH: begin
        if (!gen_last) begin
          ram_re    = 1'b1;
          ram_raddr = gen_row_r + 1'b1;
        end
        state_nxt = ST_G_CALC;
      end
      ST_G_CALC: begin
        ram_we    = 1'b1;
        ram_wdata = new_row;
        prev_nxt  = cur_r;
        cur_nxt   = nxt_row;
        if (gen_last) begin
          state_nxt = ST_RESULT;
        end else begin
          gen_row_nxt = gen_row_r + 1'b1;
          state_nxt   = ST_G_FETCH;
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_cell_nxt  = res_cell_r;
          out_done_nxt  = (op_r == lgen_pkg::OP_GEN);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      gen_row_r   <= '0;
      out_valid_r <= 1'b0;
      rows_cfg_r  <= lgen_pkg::CFG_W'(64);
      cols_cfg_r  <= lgen_pkg::CFG_W'(64);
    end else begin
      state_r     <= state_nxt;
      gen_row_r   <= gen_row_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          lgen_pkg::REG_ROWS: rows_cfg_r <= cfg_wdata;
          lgen_pkg::REG_COLS: cols_cfg_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
    op_r       <= op_nxt;
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    cell_r     <= cell_nxt;
    res_cell_r <= res_cell_nxt;
    prev_r     <= prev_nxt;
    cur_r      <= cur_nxt;
    first_r    <= first_nxt;
    out_cell_r <= out_cell_nxt;
    out_done_r <= out_done_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_cell_out        = out_cell_r;
  assign out_generation_done = out_done_r;

`ifndef ASSERT_OFF
  a_done_no_cell: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> !out_cell_r)
    else $error("generation result carries a cell value");

  a_gen_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == lgen_pkg::OP_GEN) |=> (state_r == ST_G_FIRST))
    else $error("generation beat did not start the row sweep");

  a_out_from_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RESULT))
    else $error("result appeared outside the result step");

  a_calc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_G_CALC) |-> (32'(gen_row_r) < 32'(nr)))
    else $error("generation wrote beyond the active rows");
`endif

endmodule

// ===== hdl/lgen_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lgen_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/lgen_row_calc.sv =====
// Next-generation value of one grid row from the three old rows around it.
// Depends on lgen_pkg; one lane per column, wrap at the active column count.
`timescale 1ns / 1ps

module lgen_row_calc (
  input  lgen_pkg::win_t            win,
  input  logic [lgen_pkg::NC_W-1:0] nc,
  output lgen_pkg::row_t            new_row
);

  logic [lgen_pkg::COL_W-1:0] last_col;
  lgen_pkg::row_t up_l, md_l, dn_l;
  lgen_pkg::row_t up_rb, md_rb, dn_rb;
  lgen_pkg::row_t up_r, md_r, dn_r;
  logic [3:0] nbr [lgen_pkg::MAX_COLS];

  assign last_col = lgen_pkg::COL_W'(nc - 1'b1);

  assign up_l = {win.prev[lgen_pkg::MAX_COLS-2:0], win.prev[last_col]};
  assign md_l = {win.cur[lgen_pkg::MAX_COLS-2:0],  win.cur[last_col]};
  assign dn_l = {win.nxt[lgen_pkg::MAX_COLS-2:0],  win.nxt[last_col]};

  assign up_rb = {1'b0, win.prev[lgen_pkg::MAX_COLS-1:1]};
  assign md_rb = {1'b0, win.cur[lgen_pkg::MAX_COLS-1:1]};
  assign dn_rb = {1'b0, win.nxt[lgen_pkg::MAX_COLS-1:1]};

  always_comb begin
    for (int c = 0; c < lgen_pkg::MAX_COLS; c++) begin
      up_r[c] = (lgen_pkg::COL_W'(c) == last_col) ? win.prev[0] : up_rb[c];
      md_r[c] = (lgen_pkg::COL_W'(c) == last_col) ? win.cur[0]  : md_rb[c];
      dn_r[c] = (lgen_pkg::COL_W'(c) == last_col) ? win.nxt[0]  : dn_rb[c];
      nbr[c] = {3'b0, up_l[c]} + {3'b0, win.prev[c]} + {3'b0, up_r[c]}
             + {3'b0, md_l[c]} + {3'b0, md_r[c]}
             + {3'b0, dn_l[c]} + {3'b0, win.nxt[c]} + {3'b0, dn_r[c]};
      if (32'(c) < 32'(nc)) begin
        if (win.cur[c]) begin
          new_row[c] = (nbr[c] == 4'd2) || (nbr[c] == 4'd3);
        end else begin
          new_row[c] = (nbr[c] == 4'd3);
        end
      end else begin
        new_row[c] = win.cur[c];
      end
    end
  end

endmodule
